// ===== design/csv_field_tokenizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// CSV field tokenizer assertion macros
// Shared property wrappers for the tokenizer RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_UNIT_MACROS_SVH
`define CSV_FIELD_TOKENIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define CSVFT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvft assertion failed");

// antecedent implies consequent in the next cycle
`define CSVFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvft assertion failed");

`else

`define CSVFT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CSVFT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/csvft_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Sizes, character codes, quote modes, controller/datapath structs and the
// per-byte classification function.
// ----------------------------------------------------------------------------
package csvft_pkg;

    localparam int FIELD_DEPTH = 32;
    localparam int ADDR_W      = (FIELD_DEPTH > 1) ? $clog2(FIELD_DEPTH) : 1;
    localparam int CNT_W       = $clog2(FIELD_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] DELIM_RESET = 8'h2C;

    localparam logic [1:0] MODE_UNQUOTED = 2'd0;
    localparam logic [1:0] MODE_IN_QUOTE = 2'd1;
    localparam logic [1:0] MODE_QUOTED   = 2'd2;

    typedef struct packed {
        logic       append;
        logic       pb_set;
        logic       pq_set;
        logic       clr;
        logic       emit;
        logic       emit_row;
        logic       emit_q;
        logic [1:0] mode_next;
    } hb_t;

    typedef struct packed {
        logic load;
        logic app0;
        logic app1;
        logic lastapp;
        logic em_setup;
        logic em_second;
        logic rd;
        logic push_byte;
        logic push_marker;
    } cmd_t;

    typedef struct packed {
        logic app1_en;
        logic emit1_en;
        logic last_item;
        logic em_empty;
        logic ptr_final;
        logic out_free;
    } stat_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

    // Classify one byte against the current quote mode.
    function automatic hb_t handle_byte(input logic [7:0] c, input logic [1:0] mode,
                                        input logic [7:0] delim);
        hb_t h;
        h = '0;
        h.mode_next = mode;
        h.emit_q = (mode == MODE_QUOTED);
        priority if (c == CH_CR)
        begin
            h.append = 1'b0;
        end
        else if (c == CH_QUOTE)
        begin
            if (mode == MODE_IN_QUOTE)
            begin
                h.pq_set = 1'b1;
            end
            else if (mode == MODE_UNQUOTED)
            begin
                h.mode_next = MODE_IN_QUOTE;
                h.clr = 1'b1;
            end
        end
        else if (c == delim && mode != MODE_IN_QUOTE)
        begin
            h.emit = 1'b1;
            h.mode_next = MODE_UNQUOTED;
        end
        else if (c == CH_LF && mode != MODE_IN_QUOTE)
        begin
            h.emit = 1'b1;
            h.emit_row = 1'b1;
            h.mode_next = MODE_UNQUOTED;
        end
        else if (mode != MODE_QUOTED)
        begin
            if (c == CH_BSL)
            begin
                h.pb_set = 1'b1;
            end
            else
            begin
                h.append = 1'b1;
            end
        end
        else
        begin
            // drop text after the closing quote
            h.append = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== design/csvft_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csvft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/csvft_ctrl.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer controller
// Sequences appends, field drains and the end-of-input flush for each byte.
// ----------------------------------------------------------------------------
module csvft_ctrl
    import csvft_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_APP0  = 3'd1;
    localparam logic [2:0] S_APP1  = 3'd2;
    localparam logic [2:0] S_EMSET = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;
    localparam logic [2:0] S_LAST  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       second_reg;
    logic       second_next;
    logic [2:0] after_app;
    logic [2:0] after_emit;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        after_app = stat.last_item ? S_LAST : S_IDLE;
        if (stat.emit1_en)
        begin
            after_app = S_EMSET;
        end
        after_emit = (!second_reg && stat.last_item) ? S_LAST : S_IDLE;
    end

    always_comb
    begin
        cmd = '0;
        cmd.em_second = second_reg;
        state_next = state_reg;
        second_next = second_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                second_next = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_APP0;
                end
            end
            S_APP0:
            begin
                cmd.app0 = 1'b1;
                state_next = stat.app1_en ? S_APP1 : after_app;
            end
            S_APP1:
            begin
                cmd.app1 = 1'b1;
                state_next = after_app;
            end
            S_EMSET:
            begin
                cmd.em_setup = 1'b1;
                state_next = stat.em_empty ? S_MARK : S_RD;
            end
            S_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.push_marker = 1'b1;
                    state_next = after_emit;
                end
            end
            S_RD:
            begin
                cmd.rd = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.push_byte = 1'b1;
                    state_next = stat.ptr_final ? after_emit : S_RD;
                end
            end
            S_LAST:
            begin
                cmd.lastapp = 1'b1;
                second_next = 1'b1;
                state_next = S_EMSET;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

endmodule

// ===== design/csvft_dp.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer datapath
// Byte decode, quote and escape state, field buffer with trim tracking,
// drain pointer and output register.
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_unit_macros.svh"

module csvft_dp
    import csvft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output stat_t      stat,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       field_end,
    output logic       row_end,
    output logic       field_overflow,
    output logic       stream_end
);

    // parser and field state
    logic [7:0]       delimiter_reg;
    logic [1:0]       quote_mode_reg;
    logic             pb_reg;
    logic             pq_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] first_reg;
    logic [CNT_W-1:0] lastend_reg;
    logic             ovf_reg;

    // latched plan for the accepted byte
    logic       a0_en_reg;
    logic [7:0] a0_val_reg;
    logic       a1_en_reg;
    logic [7:0] a1_val_reg;
    logic       clr_reg;
    logic       e1_en_reg;
    logic       e1_row_reg;
    logic       e1_q_reg;
    logic       la_en_reg;
    logic       e2_q_reg;
    logic       last_reg;

    // drain
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] hi_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg;
    logic       field_end_reg;
    logic       row_end_reg;
    logic       overflow_reg;
    logic       stream_end_reg;

    // decode
    hb_t        h;
    logic [1:0] hb_mode;
    logic       dec_hit;
    logic [7:0] dec_val;
    logic       use_h;
    logic       a0_en;
    logic [7:0] a0_val;
    logic       a1_en;
    logic       clr;
    logic       e1_en;
    logic       e1_row;
    logic       e1_q;
    logic [1:0] mid_mode;
    logic       mid_pb;
    logic       mid_pq;

    // append / drain helpers
    logic             app_en;
    logic [7:0]       app_val;
    logic             app_fits;
    logic             em_q;
    logic             em_row;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic             ptr_final;
    logic             push;
    logic             final_push;
    logic [7:0]       ram_rdata;

    always_comb
    begin
        dec_hit = 1'b1;
        unique case (in_byte)
            CH_N:     dec_val = CH_LF;
            CH_BSL:   dec_val = CH_BSL;
            CH_T:     dec_val = CH_TAB;
            CH_QUOTE: dec_val = CH_QUOTE;
            default:
            begin
                dec_val = in_byte;
                dec_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        hb_mode = pq_reg ? MODE_QUOTED : quote_mode_reg;
        h = handle_byte(in_byte, hb_mode, delimiter_reg);
        use_h = !(pb_reg && dec_hit) && !(pq_reg && in_byte == CH_QUOTE);
        a0_en = 1'b0;
        a0_val = in_byte;
        a1_en = 1'b0;
        clr = 1'b0;
        e1_en = 1'b0;
        e1_row = 1'b0;
        e1_q = 1'b0;
        mid_mode = quote_mode_reg;
        mid_pb = 1'b0;
        mid_pq = 1'b0;
        if (use_h)
        begin
            clr = h.clr;
            e1_en = h.emit;
            e1_row = h.emit_row;
            e1_q = h.emit_q;
            mid_mode = h.mode_next;
            mid_pb = h.pb_set;
            mid_pq = h.pq_set;
        end
        priority if (pb_reg)
        begin
            // pending backslash: decoded escape, or a literal backslash then the byte
            a0_en = 1'b1;
            a0_val = dec_hit ? dec_val : CH_BSL;
            a1_en = use_h && h.append;
        end
        else if (pq_reg && !use_h)
        begin
            a0_en = 1'b1;
            a0_val = CH_QUOTE;
        end
        else
        begin
            a0_en = use_h && h.append;
        end
    end

    // append unit
    always_comb
    begin
        app_en = (cmd.app0 && a0_en_reg && !clr_reg) || (cmd.app1 && a1_en_reg) ||
                 (cmd.lastapp && la_en_reg);
        priority if (cmd.app0)
        begin
            app_val = a0_val_reg;
        end
        else if (cmd.app1)
        begin
            app_val = a1_val_reg;
        end
        else
        begin
            app_val = CH_BSL;
        end
        app_fits = (fill_reg < CNT_W'(FIELD_DEPTH));
    end

    // drain window
    always_comb
    begin
        em_q = cmd.em_second ? e2_q_reg : e1_q_reg;
        em_row = cmd.em_second | e1_row_reg;
        lo = '0;
        hi = '0;
        if (em_q)
        begin
            hi = fill_reg;
        end
        else if (lastend_reg != '0)
        begin
            lo = first_reg;
            hi = lastend_reg;
        end
        ptr_final = ((ptr_reg + CNT_W'(1)) == hi_reg);
        push = cmd.push_byte | cmd.push_marker;
        final_push = cmd.push_marker | (cmd.push_byte & ptr_final);
    end

    assign stat.app1_en   = a1_en_reg;
    assign stat.emit1_en  = e1_en_reg;
    assign stat.last_item = last_reg;
    assign stat.em_empty  = (lo >= hi);
    assign stat.ptr_final = ptr_final;
    assign stat.out_free  = !out_valid_reg || out_ready;

    csvft_ram #(
        .WIDTH (8),
        .DEPTH (FIELD_DEPTH)
    ) u_field_ram (
        .clk   (clk),
        .we    (app_en && app_fits),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (app_val),
        .re    (cmd.rd),
        .raddr (ptr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg  <= DELIM_RESET;
            quote_mode_reg <= MODE_UNQUOTED;
            pb_reg         <= 1'b0;
            pq_reg         <= 1'b0;
            fill_reg       <= '0;
            first_reg      <= '0;
            lastend_reg    <= '0;
            ovf_reg        <= 1'b0;
            a0_en_reg      <= 1'b0;
            a1_en_reg      <= 1'b0;
            clr_reg        <= 1'b0;
            e1_en_reg      <= 1'b0;
            e1_row_reg     <= 1'b0;
            e1_q_reg       <= 1'b0;
            la_en_reg      <= 1'b0;
            e2_q_reg       <= 1'b0;
            last_reg       <= 1'b0;
            ptr_reg        <= '0;
            hi_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                delimiter_reg <= cfg_wr_data;
            end

            if (cmd.load)
            begin
                a0_en_reg      <= a0_en;
                a1_en_reg      <= a1_en;
                clr_reg        <= clr;
                e1_en_reg      <= e1_en;
                e1_row_reg     <= e1_row;
                e1_q_reg       <= e1_q;
                la_en_reg      <= in_last && mid_pb;
                e2_q_reg       <= mid_pq || (mid_mode == MODE_QUOTED);
                last_reg       <= in_last;
                quote_mode_reg <= in_last ? MODE_UNQUOTED : mid_mode;
                pb_reg         <= !in_last && mid_pb;
                pq_reg         <= !in_last && mid_pq;
            end

            priority if (final_push || (cmd.app0 && clr_reg))
            begin
                fill_reg    <= '0;
                first_reg   <= '0;
                lastend_reg <= '0;
                ovf_reg     <= 1'b0;
            end
            else if (app_en)
            begin
                if (app_fits)
                begin
                    if (!is_space(app_val))
                    begin
                        if (lastend_reg == '0)
                        begin
                            first_reg <= fill_reg;
                        end
                        lastend_reg <= fill_reg + CNT_W'(1);
                    end
                    fill_reg <= fill_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            else
            begin
                // hold the field state
            end

            if (cmd.em_setup)
            begin
                ptr_reg <= lo;
                hi_reg  <= hi;
            end
            else if (cmd.push_byte)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a0_val_reg <= a0_val;
            a1_val_reg <= in_byte;
        end
        if (push)
        begin
            out_byte_reg   <= cmd.push_byte ? ram_rdata : 8'd0;
            byte_valid_reg <= cmd.push_byte;
            field_end_reg  <= cmd.push_byte ? ptr_final : !em_row;
            row_end_reg    <= cmd.push_byte ? (ptr_final & em_row) : em_row;
            overflow_reg   <= ovf_reg;
            stream_end_reg <= final_push & cmd.em_second;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign byte_valid     = byte_valid_reg;
    assign field_end      = field_end_reg;
    assign row_end        = row_end_reg;
    assign field_overflow = overflow_reg;
    assign stream_end     = stream_end_reg;

    `CSVFT_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CNT_W'(FIELD_DEPTH))
    `CSVFT_ASSERT_IMPLY(a_trim_order, clk, rst_n, lastend_reg != '0,
                        (first_reg < lastend_reg) && (lastend_reg <= fill_reg))
    `CSVFT_ASSERT_IMPLY(a_one_pending, clk, rst_n, 1'b1, !(pb_reg && pq_reg))
    `CSVFT_ASSERT_IMPLY(a_ptr_range, clk, rst_n, cmd.push_byte, ptr_reg < hi_reg)
    `CSVFT_ASSERT_NEXT(a_clear_after_field, clk, rst_n, final_push,
                       (fill_reg == '0) && !ovf_reg)

endmodule

// ===== design/csv_field_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Streaming field and row splitter with quoting, escapes and trimming.
// ----------------------------------------------------------------------------
// One byte is accepted at a time. A plain byte is accepted, then written to
// the buffer; a backslash that turns out literal adds a second buffer write.
// A byte that closes a field also drains the 32-entry field buffer: a setup
// step, then a RAM read and an output register load per emitted byte, or a
// single push for a bare marker; end of input adds a step that appends a
// waiting backslash, then a flush of the same shape. A stalled output holds
// the drain, and the next byte is taken once the drain is done while its
// last result may still wait in the output register.
module csv_field_tokenizer_unit
    import csvft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       field_end,
    output logic       row_end,
    output logic       field_overflow,
    output logic       stream_end
);

    cmd_t  cmd;
    stat_t stat;

    csvft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csvft_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .field_end      (field_end),
        .row_end        (row_end),
        .field_overflow (field_overflow),
        .stream_end     (stream_end)
    );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// Streams directed and random CSV text through the tokenizer under several
// delimiter settings, predicts every field byte and end marker in a local
// model of the splitter, and checks each output transaction in order.
// ----------------------------------------------------------------------------
module tb
    import csvft_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_GAP   = 100;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_PHASE  = 1;
    localparam int NUM_PHASES  = 8;

    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_B    = 8'h62;
    localparam logic [7:0] CH_Q    = 8'h71;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_Z    = 8'h7A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_end;
        logic       row_end;
        logic       field_overflow;
        logic       stream_end;
    } token_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       sync;
    } stim_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       row_end;
    logic       field_overflow;
    logic       stream_end;

    csv_field_tokenizer_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .field_end      (field_end),
        .row_end        (row_end),
        .field_overflow (field_overflow),
        .stream_end     (stream_end)
    );

    // Splitter model state
    logic [7:0] sep_char;
    logic [1:0] q_mode;
    logic       pend_q;
    logic       pend_bs;
    logic [7:0] field_buf [FIELD_DEPTH];
    int         fill;
    int         first_ns;
    int         last_ns_end;
    logic       ovf;

    token_t expected_tokens [$];
    stim_t  pending_bytes [$];
    stim_t  next_item;

    int   queued_count = 0;
    int   offered_items = 0;
    int   accepted_items = 0;
    int   cycle_count = 0;
    int   mismatch_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   phase_no = 0;
    int   long_hold_left = 0;
    bit   long_hold_done = 1'b0;
    logic sync_next = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Splitter model
    // ------------------------------------------------------------------
    function automatic logic blank_char(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void reset_field();
        fill        = 0;
        first_ns    = 0;
        last_ns_end = 0;
        ovf         = 1'b0;
    endfunction

    function automatic void store_char(input logic [7:0] c);
        if (fill < FIELD_DEPTH)
        begin
            field_buf[fill[ADDR_W-1:0]] = c;
            if (!blank_char(c))
            begin
                if (last_ns_end == 0)
                    first_ns = fill;
                last_ns_end = fill + 1;
            end
            fill++;
        end
        else
        begin
            ovf = 1'b1;
        end
    endfunction

    function automatic void close_field(input logic row);
        int     lo;
        int     hi;
        int     i;
        token_t tok;
        lo = 0;
        hi = 0;
        if (q_mode == MODE_QUOTED)
        begin
            hi = fill;
        end
        else if (last_ns_end != 0)
        begin
            lo = first_ns;
            hi = last_ns_end;
        end
        if (lo >= hi)
        begin
            // empty field: bare marker only
            tok                = '0;
            tok.field_end      = !row;
            tok.row_end        = row;
            tok.field_overflow = ovf;
            expected_tokens.push_back(tok);
        end
        else
        begin
            for (i = lo; i < hi; i++)
            begin
                tok                = '0;
                tok.out_byte       = field_buf[i[ADDR_W-1:0]];
                tok.byte_valid     = 1'b1;
                tok.field_end      = (i == hi - 1);
                tok.row_end        = row && (i == hi - 1);
                tok.field_overflow = ovf;
                expected_tokens.push_back(tok);
            end
        end
    endfunction

    function automatic void step_char(input logic [7:0] c);
        if (c == CH_CR)
        begin
            // drop carriage returns
        end
        else if (c == CH_QUOTE)
        begin
            if (q_mode == MODE_IN_QUOTE)
            begin
                pend_q = 1'b1;
            end
            else if (q_mode == MODE_UNQUOTED)
            begin
                q_mode = MODE_IN_QUOTE;
                reset_field();
            end
        end
        else if (c == sep_char && q_mode != MODE_IN_QUOTE)
        begin
            close_field(1'b0);
            reset_field();
            q_mode = MODE_UNQUOTED;
        end
        else if (c == CH_LF && q_mode != MODE_IN_QUOTE)
        begin
            close_field(1'b1);
            reset_field();
            q_mode = MODE_UNQUOTED;
        end
        else if (q_mode != MODE_QUOTED)
        begin
            if (c == CH_BSL)
                pend_bs = 1'b1;
            else
                store_char(c);
        end
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c, input logic last);
        token_t tok;
        if (pend_bs)
        begin
            pend_bs = 1'b0;
            if (c == CH_N)
                store_char(CH_LF);
            else if (c == CH_BSL)
                store_char(CH_BSL);
            else if (c == CH_T)
                store_char(CH_TAB);
            else if (c == CH_QUOTE)
                store_char(CH_QUOTE);
            else
            begin
                store_char(CH_BSL);
                step_char(c);
            end
        end
        else if (pend_q)
        begin
            pend_q = 1'b0;
            if (c == CH_QUOTE)
            begin
                store_char(CH_QUOTE);
            end
            else
            begin
                q_mode = MODE_QUOTED;
                step_char(c);
            end
        end
        else
        begin
            step_char(c);
        end

        if (last)
        begin
            // resolve any lookahead, flush the open field, tag the final result
            if (pend_bs)
            begin
                store_char(CH_BSL);
                pend_bs = 1'b0;
            end
            if (pend_q)
            begin
                q_mode = MODE_QUOTED;
                pend_q = 1'b0;
            end
            close_field(1'b1);
            tok = expected_tokens.pop_back();
            tok.stream_end = 1'b1;
            expected_tokens.push_back(tok);
            reset_field();
            q_mode = MODE_UNQUOTED;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic void push_stim(input logic [7:0] b, input logic last);
        stim_t s;
        s.data    = b;
        s.last    = last;
        s.sync    = sync_next;
        sync_next = 1'b0;
        pending_bytes.push_back(s);
        queued_count++;
    endfunction

    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 7))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return ($urandom_range(0, 1) != 0) ? CH_VT : CH_FF;
            default: return CH_A + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 4))
            0: return CH_N;
            1: return CH_BSL;
            2: return CH_T;
            3: return CH_QUOTE;
            default: return pick_text();
        endcase
    endfunction

    function automatic void queue_directed();
        push_stim(CH_LF, 1'b0);
        push_stim(CH_SPACE, 1'b0);
        push_stim(8'h00, 1'b0);
        push_stim(8'hFF, 1'b0);
        push_stim(CH_TAB, 1'b0);
        push_stim(DELIM_RESET, 1'b0);
        // junk before the quote, a doubled quote, junk after the close
        push_stim(CH_X, 1'b0);
        push_stim(CH_QUOTE, 1'b0);
        push_stim(CH_A, 1'b0);
        push_stim(CH_QUOTE, 1'b0);
        push_stim(CH_QUOTE, 1'b0);
        push_stim(CH_B, 1'b0);
        push_stim(CH_QUOTE, 1'b0);
        push_stim(CH_Z, 1'b0);
        push_stim(DELIM_RESET, 1'b0);
        push_stim(CH_BSL, 1'b0);
        push_stim(CH_N, 1'b0);
        push_stim(CH_BSL, 1'b0);
        push_stim(CH_Q, 1'b0);
        push_stim(CH_CR, 1'b0);
        push_stim(CH_LF, 1'b0);
        // backslash left waiting at end of input
        push_stim(CH_BSL, 1'b1);
        // quote left waiting at end of input
        push_stim(CH_QUOTE, 1'b0);
        push_stim(CH_Q, 1'b0);
        push_stim(CH_QUOTE, 1'b1);
        // empty field, then empty final field
        push_stim(DELIM_RESET, 1'b1);
    endfunction

    function automatic void queue_random(input int items);
        int first;
        int kind;
        int len;
        int i;
        int r;
        bit sync_done;
        first     = queued_count;
        sync_done = 1'b0;
        while (queued_count - first < items)
        begin
            if (!sync_done && queued_count - first >= items / 2)
            begin
                sync_next = 1'b1;
                sync_done = 1'b1;
            end
            kind = $urandom_range(0, 19);
            if (kind < 7)
            begin
                len = $urandom_range(0, 6);
                for (i = 0; i < len; i++)
                    push_stim(pick_text(), 1'b0);
            end
            else if (kind < 11)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_stim(pick_text(), 1'b0);
                push_stim(CH_QUOTE, 1'b0);
                len = $urandom_range(0, 5);
                for (i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 5))
                        0:
                        begin
                            push_stim(CH_QUOTE, 1'b0);
                            push_stim(CH_QUOTE, 1'b0);
                        end
                        1: push_stim(sep_char, 1'b0);
                        2: push_stim(CH_LF, 1'b0);
                        3:
                        begin
                            push_stim(CH_BSL, 1'b0);
                            push_stim(pick_escape(), 1'b0);
                        end
                        default: push_stim(pick_text(), 1'b0);
                    endcase
                end
                push_stim(CH_QUOTE, 1'b0);
                if ($urandom_range(0, 3) == 0)
                    push_stim(pick_text(), 1'b0);
            end
            else if (kind < 14)
            begin
                len = $urandom_range(1, 3);
                for (i = 0; i < len; i++)
                begin
                    push_stim(CH_BSL, 1'b0);
                    push_stim(pick_escape(), 1'b0);
                end
            end
            else if (kind < 16)
            begin
                // long runs; a few go past the field buffer
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 40)
                                                   : $urandom_range(8, 20);
                for (i = 0; i < len; i++)
                    push_stim(pick_text(), 1'b0);
            end
            else if (kind < 18)
            begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                    push_stim(8'($urandom_range(0, 255)), 1'b0);
            end

            r = $urandom_range(0, 19);
            if (r < 12)
                push_stim(sep_char, 1'b0);
            else if (r < 16)
                push_stim(CH_LF, 1'b0);
            else if (r < 18)
            begin
                push_stim(CH_CR, 1'b0);
                push_stim(CH_LF, 1'b0);
            end
            else
                push_stim(($urandom_range(0, 1) != 0) ? sep_char : CH_LF, 1'b1);
        end
        push_stim(pick_text(), 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one transaction outstanding at a time
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && accepted_items == offered_items)
        begin
            if (pending_bytes.size() != 0)
                next_item = pending_bytes[0];
            // hold a sync item until every expected result has drained
            if (pending_bytes.size() == 0 || $urandom_range(0, 99) < send_idle_pct ||
                (next_item.sync && expected_tokens.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                next_item = pending_bytes.pop_front();
                in_byte   <= next_item.data;
                in_last   <= next_item.last;
                in_valid  <= 1'b1;
                offered_items++;
            end
        end
    end

    // Output receiver, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (long_hold_left > 0)
        begin
            long_hold_left--;
            out_ready <= 1'b0;
        end
        else if (phase_no == HOLD_PHASE && !long_hold_done && out_valid)
        begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        token_t want;
        token_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_tokens.size());
            $display("Verification failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {out_byte, byte_valid, field_end, row_end, field_overflow, stream_end};
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
                    check_field("field_end", 8'(want.field_end), 8'(got.field_end));
                    check_field("row_end", 8'(want.row_end), 8'(got.row_end));
                    check_field("field_overflow", 8'(want.field_overflow),
                                8'(got.field_overflow));
                    check_field("stream_end", 8'(want.stream_end), 8'(got.stream_end));
                end
            end
            if (in_valid && in_ready)
            begin
                tokenize_byte(in_byte, in_last);
                accepted_items++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, then one delimiter setting per phase
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        int         p;
        int         items;
        logic [7:0] next_delim;
        sep_char = DELIM_RESET;
        q_mode   = MODE_UNQUOTED;
        pend_q   = 1'b0;
        pend_bs  = 1'b0;
        reset_field();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            items      = 0;
            next_delim = DELIM_RESET;
            case (p)
                1: begin next_delim = 8'h00;       items = 40; end
                2: begin next_delim = 8'hFF;       items = 35; end
                3: begin next_delim = CH_SEMI;     items = 35; end
                4: begin next_delim = CH_LF;       items = 25; end
                5: begin next_delim = CH_QUOTE;    items = 20; end
                6: begin next_delim = CH_CR;       items = 15; end
                7: begin next_delim = DELIM_RESET; items = 30; end
                default: items = 0;
            endcase
            phase_no = p;
            if (p <= 1)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 47;
            end
            else if (p <= 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // phase 0 runs on the reset delimiter
            if (p != 0)
            begin
                sep_char = next_delim;
                cfg_wr_data <= next_delim;
                cfg_wr_en   <= 1'b1;
                @(negedge clk);
                cfg_wr_en <= 1'b0;
                queue_random(items);
            end
            else
            begin
                queue_directed();
            end

            while (pending_bytes.size() != 0 || accepted_items != offered_items ||
                   expected_tokens.size() != 0)
                @(negedge clk);
            // let a trailing no-result byte settle before touching the register
            repeat (DRAIN_GAP) @(negedge clk);
        end

        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/csvft_pkg.sv
design/csvft_ram.sv
design/csvft_ctrl.sv
design/csvft_dp.sv
design/csv_field_tokenizer_unit.sv
tb/sv/tb.sv
